// ===== rtl/clp_pkg.sv =====
package clp_pkg;

    localparam int unsigned CompW    = 16;
    localparam int unsigned IndexW   = 32;
    localparam int unsigned DivSteps = 4;   // quotient bits resolved per divider stage
    localparam int unsigned DivStages = CompW / DivSteps;
    localparam int unsigned WeightW  = 8;
    localparam int unsigned WsumW    = 10;  // sum of three 8-bit weights
    localparam int unsigned DividendW = CompW + WsumW;
    localparam int unsigned CfgAddrW = 3;
    localparam int unsigned CfgDataW = 16;

    typedef enum logic [2:0] {
        MODE_WOB  = 3'd0,
        MODE_BOW  = 3'd1,
        MODE_GRAY = 3'd2,
        MODE_RGB  = 3'd3,
        MODE_CMYK = 3'd4
    } mode_t;

    typedef enum logic [CfgAddrW-1:0] {
        CFG_MODE     = 3'd0,
        CFG_MAX_GRAY = 3'd1,
        CFG_DEPTH    = 3'd2,
        CFG_RED_W    = 3'd3,
        CFG_GREEN_W  = 3'd4,
        CFG_BLUE_W   = 3'd5
    } cfg_addr_t;

    localparam logic [2:0]  ModeReset     = 3'd3;
    localparam logic [15:0] MaxGrayReset  = 16'd255;
    localparam logic [4:0]  DepthReset    = 5'd24;
    localparam logic [4:0]  DepthBytePack = 5'd24;
    localparam logic [7:0]  RedWReset     = 8'd30;
    localparam logic [7:0]  GreenWReset   = 8'd59;
    localparam logic [7:0]  BlueWReset    = 8'd11;
    localparam logic [15:0] FullScale     = 16'hFFFF;
    localparam logic [15:0] HalfScale     = 16'h7FFF;

    // Restoring divider working word: partial remainder and shifting dividend/quotient.
    typedef struct packed {
        logic [WsumW-1:0] rem;
        logic [CompW-1:0] bits;
    } div_word_t;

    // floor(x / 65535) via 2^16 reciprocal and up to two corrections.
    function automatic logic [16:0] div65535(input logic [31:0] x);
        logic [16:0] q0;
        logic [16:0] r;
        begin
            q0 = {1'b0, x[31:16]};
            r  = {1'b0, x[15:0]} + q0;
            if (r >= 17'd131070)
                div65535 = q0 + 17'd2;
            else if (r >= 17'd65535)
                div65535 = q0 + 17'd1;
            else
                div65535 = q0;
        end
    endfunction

    // Bits per color for a given pixel depth (depth / 3).
    function automatic logic [3:0] field_bits(input logic [4:0] depth);
        begin
            case (depth)
                5'd0, 5'd1, 5'd2:    field_bits = 4'd0;
                5'd3, 5'd4, 5'd5:    field_bits = 4'd1;
                5'd6, 5'd7, 5'd8:    field_bits = 4'd2;
                5'd9, 5'd10, 5'd11:  field_bits = 4'd3;
                5'd12, 5'd13, 5'd14: field_bits = 4'd4;
                5'd15, 5'd16, 5'd17: field_bits = 4'd5;
                5'd18, 5'd19, 5'd20: field_bits = 4'd6;
                5'd21, 5'd22, 5'd23: field_bits = 4'd7;
                5'd24, 5'd25, 5'd26: field_bits = 4'd8;
                5'd27, 5'd28, 5'd29: field_bits = 4'd9;
                default:             field_bits = 4'd10;
            endcase
        end
    endfunction

endpackage

// ===== rtl/clp_div.sv =====
module clp_div
    import clp_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [DividendW-1:0] dividend,
    input  logic [WsumW-1:0]     divisor,
    output logic [CompW-1:0]     quotient
);

    div_word_t stage_reg  [DivStages];
    div_word_t stage_next [DivStages];

    always_comb
    begin
        div_word_t   w;
        logic [WsumW:0] t;
        for (int s = 0; s < DivStages; s++)
        begin
            if (s == 0)
            begin
                w.rem  = dividend[DividendW-1:CompW];
                w.bits = dividend[CompW-1:0];
            end
            else
            begin
                w = stage_reg[s-1];
            end
            for (int k = 0; k < DivSteps; k++)
            begin
                t = {w.rem, w.bits[CompW-1]};
                if (t >= {1'b0, divisor})
                begin
                    w.rem  = WsumW'(t - {1'b0, divisor});
                    w.bits = {w.bits[CompW-2:0], 1'b1};
                end
                else
                begin
                    w.rem  = t[WsumW-1:0];
                    w.bits = {w.bits[CompW-2:0], 1'b0};
                end
            end
            stage_next[s] = w;
        end
    end

    // Payload only: advance all stages together.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DivStages; s++)
                stage_reg[s] <= stage_next[s];
        end
    end

    assign quotient = stage_reg[DivStages-1].bits;

endmodule

// ===== rtl/device_color_index_packer.sv =====
// Channel   Handshake                Payload
// input     in_valid / in_ready      red_or_cyan, green_or_magenta, blue_or_yellow,
//                                    black, alpha (16 bits each)
// output    out_valid / out_ready    color_index (32 bits)
// config    cfg_we                   cfg_addr (3 bits), cfg_data (16 bits)
//
// One item per clock while the output is not stalled; ten register stages,
// four of them in the gray luminance divider (four quotient bits each).
// All stages advance together when the output register is empty or taken.
// Reset clears the valid bits and loads the register defaults.
// A stall holds every stage; no item is lost or repeated.
module device_color_index_packer
    import clp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CompW-1:0]    red_or_cyan,
    input  logic [CompW-1:0]    green_or_magenta,
    input  logic [CompW-1:0]    blue_or_yellow,
    input  logic [CompW-1:0]    black,
    input  logic [CompW-1:0]    alpha,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [IndexW-1:0]   color_index,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgDataW-1:0] cfg_data
);

    localparam int unsigned Depth = 6 + DivStages;

    // ---------------------------------------------------------------- config
    logic [2:0]         mode_reg;
    logic [15:0]        max_gray_reg;
    logic [4:0]         depth_reg;
    logic [WeightW-1:0] red_w_reg;
    logic [WeightW-1:0] green_w_reg;
    logic [WeightW-1:0] blue_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= ModeReset;
            max_gray_reg <= MaxGrayReset;
            depth_reg    <= DepthReset;
            red_w_reg    <= RedWReset;
            green_w_reg  <= GreenWReset;
            blue_w_reg   <= BlueWReset;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MODE:     mode_reg     <= cfg_data[2:0];
                CFG_MAX_GRAY: max_gray_reg <= cfg_data;
                CFG_DEPTH:    depth_reg    <= cfg_data[4:0];
                CFG_RED_W:    red_w_reg    <= cfg_data[7:0];
                CFG_GREEN_W:  green_w_reg  <= cfg_data[7:0];
                CFG_BLUE_W:   blue_w_reg   <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    logic [WsumW-1:0] wsum;
    logic [3:0]       nbits;
    logic [9:0]       level_max;

    assign wsum      = WsumW'(red_w_reg) + WsumW'(green_w_reg) + WsumW'(blue_w_reg);
    assign nbits     = field_bits(depth_reg);
    assign level_max = 10'((11'd1 << nbits) - 11'd1);

    // ---------------------------------------------------------- stage control
    logic [Depth-1:0] v_reg;
    logic             adv;

    // Whole pipe moves when the output slot is free or being drained.
    assign adv      = !v_reg[Depth-1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[Depth-2:0], in_valid};
    end

    // ----------------------------------------- stage 1: alpha products
    logic [31:0]      p1_reg [3];
    logic [CompW-1:0] a1_reg;
    logic [CompW-1:0] raw1_reg [4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg[0]   <= red_or_cyan * alpha;
            p1_reg[1]   <= green_or_magenta * alpha;
            p1_reg[2]   <= blue_or_yellow * alpha;
            a1_reg      <= alpha;
            raw1_reg[0] <= red_or_cyan;
            raw1_reg[1] <= green_or_magenta;
            raw1_reg[2] <= blue_or_yellow;
            raw1_reg[3] <= black;
        end
    end

    // ----------------------------------------- stage 2: blend toward white
    logic [CompW-1:0]  b2_reg [3];
    logic [IndexW-1:0] cmyk2_reg;
    logic [CompW-1:0]  b2_next [3];
    logic [IndexW-1:0] cmyk2_next;

    always_comb
    begin
        logic [16:0] bq;
        for (int i = 0; i < 3; i++)
        begin
            bq = div65535(p1_reg[i]);
            b2_next[i] = bq[CompW-1:0] + (FullScale - a1_reg);
        end
        cmyk2_next = {raw1_reg[0][15:8], raw1_reg[1][15:8],
                      raw1_reg[2][15:8], raw1_reg[3][15:8]};
        // All-ones is reserved: flip the low bit.
        if (cmyk2_next == '1)
            cmyk2_next[0] = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b2_reg    <= b2_next;
            cmyk2_reg <= cmyk2_next;
        end
    end

    // ---------------------------------- stage 3: weight and level products
    logic [23:0]       gp3_reg [3];
    logic [25:0]       rp3_reg [3];
    logic [IndexW-1:0] side3_reg;
    logic [IndexW-1:0] side3_next;
    logic              bright;

    assign bright = (b2_reg[0] | b2_reg[1] | b2_reg[2]) > HalfScale;

    always_comb
    begin
        case (mode_reg)
            MODE_WOB:  side3_next = IndexW'(bright);
            MODE_BOW:  side3_next = IndexW'(!bright);
            MODE_RGB:  side3_next = {8'd0, b2_reg[0][15:8], b2_reg[1][15:8],
                                     b2_reg[2][15:8]};
            MODE_CMYK: side3_next = cmyk2_reg;
            default:   side3_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gp3_reg[0] <= b2_reg[0] * red_w_reg;
            gp3_reg[1] <= b2_reg[1] * green_w_reg;
            gp3_reg[2] <= b2_reg[2] * blue_w_reg;
            for (int i = 0; i < 3; i++)
                rp3_reg[i] <= b2_reg[i] * level_max;
            side3_reg <= side3_next;
        end
    end

    // ------------------------------- stage 4: luminance sum, rgb packing
    logic [DividendW-1:0] dvd4_reg;
    logic [IndexW-1:0]    side4_reg;
    logic [IndexW-1:0]    side4_next;
    logic [9:0]           lv [3];
    logic [4:0]           sh1;
    logic [4:0]           sh2;

    always_comb
    begin
        logic [16:0] lq;
        for (int i = 0; i < 3; i++)
        begin
            lq = div65535({6'd0, rp3_reg[i]});
            lv[i] = lq[9:0];
        end
        sh1 = {1'b0, nbits};
        sh2 = {nbits, 1'b0};
        side4_next = side3_reg;
        if (mode_reg == MODE_RGB && depth_reg != DepthBytePack)
            side4_next = (IndexW'(lv[0]) << sh2) + (IndexW'(lv[1]) << sh1)
                         + IndexW'(lv[2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dvd4_reg  <= DividendW'(gp3_reg[0]) + DividendW'(gp3_reg[1])
                         + DividendW'(gp3_reg[2]) + DividendW'(wsum >> 1);
            side4_reg <= side4_next;
        end
    end

    // --------------------------------------- stages 5-8: luminance divide
    logic [CompW-1:0]  lum;
    logic [IndexW-1:0] sidep_reg [DivStages];

    clp_div u_div (
        .clk      (clk),
        .en       (adv),
        .dividend (dvd4_reg),
        .divisor  (wsum),
        .quotient (lum)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sidep_reg[0] <= side4_reg;
            for (int s = 1; s < DivStages; s++)
                sidep_reg[s] <= sidep_reg[s-1];
        end
    end

    // ------------------------------------------ stage 9: scale to max gray
    logic [31:0]       gs9_reg;
    logic [IndexW-1:0] side9_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gs9_reg   <= lum * max_gray_reg;
            side9_reg <= sidep_reg[DivStages-1];
        end
    end

    // -------------------------------------- stage 10: round, select, output
    logic [IndexW-1:0] out_reg;
    logic [IndexW-1:0] out_next;

    always_comb
    begin
        out_next = side9_reg;
        if (mode_reg == MODE_GRAY)
        begin
            if (wsum == '0)
                out_next = '0;
            else
                out_next = IndexW'(div65535(gs9_reg + 32'(HalfScale)));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign out_valid   = v_reg[Depth-1];
    assign color_index = out_reg;

    // -------------------------------------------------------- assertions
    ap_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready disagrees with output slot state");

    ap_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (mode_reg == MODE_WOB || mode_reg == MODE_BOW))
        |-> (color_index[IndexW-1:1] == '0))
        else $error("one-bit mode produced a wide index");

    ap_cmyk_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mode_reg == MODE_CMYK) |-> (color_index != '1))
        else $error("reserved all-ones cmyk index produced");

endmodule

// ===== tb/tb_device_color_index_packer.sv =====
`timescale 1ns / 100ps

module tb_device_color_index_packer;
    import clp_pkg::*;

    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned PipeDepth  = 10;
    localparam int unsigned RandItems  = 600;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [CompW-1:0]    red_or_cyan;
    logic [CompW-1:0]    green_or_magenta;
    logic [CompW-1:0]    blue_or_yellow;
    logic [CompW-1:0]    black;
    logic [CompW-1:0]    alpha;
    logic                out_valid;
    logic                out_ready;
    logic [IndexW-1:0]   color_index;
    logic                cfg_we;
    logic [CfgAddrW-1:0] cfg_addr;
    logic [CfgDataW-1:0] cfg_data;

    device_color_index_packer dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .red_or_cyan      (red_or_cyan),
        .green_or_magenta (green_or_magenta),
        .blue_or_yellow   (blue_or_yellow),
        .black            (black),
        .alpha            (alpha),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .color_index      (color_index),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_data         (cfg_data)
    );

    // One pixel as offered on the input channel.
    typedef struct packed {
        logic [15:0] c0;
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] k;
        logic [15:0] a;
    } pixel_t;

    // Directed row: pixel plus an optional hand-typed index.
    typedef struct {
        pixel_t      px;
        bit          typed;
        logic [31:0] index;
    } pixel_row_t;

    // Shadow copy of the register file.
    logic [2:0]  sh_mode;
    logic [15:0] sh_max_gray;
    logic [4:0]  sh_depth;
    logic [7:0]  sh_wr, sh_wg, sh_wb;

    logic [31:0] pending_index[$];
    int          mismatches;
    int          results_seen;
    int          cycle_count;
    bit          hold_off;      // long receiver stall requested by the stimulus

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Blend one component toward white by the transparent share.
    function automatic logic [15:0] toward_white(input logic [15:0] v, input logic [15:0] a);
        logic [31:0] prod;
        begin
            if (a == 16'hFFFF)
                return v;
            prod = v * a;
            return 16'(prod / 32'd65535) + (16'hFFFF - a);
        end
    endfunction

    function automatic logic [31:0] predict_index(input pixel_t px);
        logic [15:0] r, g, b;
        logic [63:0] wsum, lum, m, acc;
        int unsigned n;
        begin
            r = px.c0;
            g = px.c1;
            b = px.c2;
            if (sh_mode <= MODE_RGB)
            begin
                r = toward_white(r, px.a);
                g = toward_white(g, px.a);
                b = toward_white(b, px.a);
            end
            case (sh_mode)
                MODE_WOB:  return ((r | g | b) > 16'h7FFF) ? 32'd1 : 32'd0;
                MODE_BOW:  return ((r | g | b) > 16'h7FFF) ? 32'd0 : 32'd1;
                MODE_GRAY:
                begin
                    wsum = 64'(sh_wr) + 64'(sh_wg) + 64'(sh_wb);
                    if (wsum == 0)
                        return 32'd0;
                    lum = (64'(r) * sh_wr + 64'(g) * sh_wg + 64'(b) * sh_wb + wsum / 2) / wsum;
                    return 32'((lum * sh_max_gray + 64'd32767) / 64'd65535);
                end
                MODE_RGB:
                begin
                    if (sh_depth == 5'd24)
                        return {8'd0, r[15:8], g[15:8], b[15:8]};
                    n = sh_depth / 3;
                    m = (64'd1 << n) - 1;
                    acc = ((64'(r) * m / 65535) << (2 * n)) + ((64'(g) * m / 65535) << n)
                          + (64'(b) * m / 65535);
                    return acc[31:0];
                end
                MODE_CMYK:
                begin
                    acc[31:0] = {px.c0[15:8], px.c1[15:8], px.c2[15:8], px.k[15:8]};
                    if (acc[31:0] == 32'hFFFF_FFFF)
                        return 32'hFFFF_FFFE;
                    return acc[31:0];
                end
                default:   return 32'd0;
            endcase
        end
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t px;
        begin
            px = 80'({$urandom, $urandom, $urandom});
            // Bias toward full scale, opaque and fully transparent so extremes show up often.
            case ($urandom_range(0, 5))
                0: px.a = 16'hFFFF;
                1: px.a = 16'h0000;
                2: px.c0 = 16'hFFFF;
                default: ;
            endcase
            return px;
        end
    endfunction

    // Mostly no idle gap, sometimes a short one, an occasional long one.
    function automatic int gap_len();
        begin
            case ($urandom_range(0, 19))
                0:       return $urandom_range(10, 40);
                1, 2, 3: return $urandom_range(1, 4);
                default: return 0;
            endcase
        end
    endfunction

    // Write one register; the strobe is released before the task returns.
    task automatic write_reg(input cfg_addr_t idx, input logic [15:0] value);
        begin
            cfg_we   <= 1'b1;
            cfg_addr <= idx;
            cfg_data <= value;
            @(posedge clk);
            cfg_we   <= 1'b0;
            @(posedge clk);
            case (idx)
                CFG_MODE:     sh_mode     = value[2:0];
                CFG_MAX_GRAY: sh_max_gray = value;
                CFG_DEPTH:    sh_depth    = value[4:0];
                CFG_RED_W:    sh_wr       = value[7:0];
                CFG_GREEN_W:  sh_wg       = value[7:0];
                CFG_BLUE_W:   sh_wb       = value[7:0];
                default: ;
            endcase
        end
    endtask

    // Offer one pixel and hold it until taken; queue its expected index.
    // Valid stays high after acceptance so the next item can follow at once.
    task automatic send_pixel(input pixel_t px, input bit typed, input logic [31:0] index);
        logic [31:0] want;
        int          gap;
        begin
            gap = gap_len();
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            want = predict_index(px);
            if (typed && want != index)
                $display("%0t: typed index %h disagrees with predicted %h", $time, index, want);
            pending_index.push_back(typed ? index : want);
            in_valid         <= 1'b1;
            red_or_cyan      <= px.c0;
            green_or_magenta <= px.c1;
            blue_or_yellow   <= px.c2;
            black            <= px.k;
            alpha            <= px.a;
            do
                @(posedge clk);
            while (!in_ready);
        end
    endtask

    // Drop valid, drain, then let the pipe settle before touching a register.
    task automatic wait_idle();
        begin
            in_valid <= 1'b0;
            while (pending_index.size() != 0)
                @(posedge clk);
            repeat (PipeDepth + 2) @(posedge clk);
        end
    endtask

    // Output side: random stalls plus the long hold-off.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                for (int i = 0; i < 60; i++)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            stall = gap_len();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Compare each accepted index with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_index.size() == 0)
            begin
                $display("%0t: unexpected index, expected none, actual %h", $time, color_index);
                mismatches++;
            end
            else
            begin
                logic [31:0] want;
                want = pending_index.pop_front();
                if (color_index !== want)
                begin
                    $display("%0t: color_index expected %h actual %h", $time, want, color_index);
                    mismatches++;
                end
                results_seen++;
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    pixel_row_t rows[$];

    task automatic add_row(input pixel_t px, input bit typed, input logic [31:0] index);
        pixel_row_t row;
        begin
            row.px = px;
            row.typed = typed;
            row.index = index;
            rows.push_back(row);
        end
    endtask

    task automatic run_rows();
        begin
            foreach (rows[i])
                send_pixel(rows[i].px, rows[i].typed, rows[i].index);
            rows.delete();
            wait_idle();
        end
    endtask

    initial
    begin
        logic [4:0] depth_pick[4];
        rst_n = 1'b0;
        in_valid = 1'b0;
        red_or_cyan = '0;
        green_or_magenta = '0;
        blue_or_yellow = '0;
        black = '0;
        alpha = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        mismatches = 0;
        results_seen = 0;
        cycle_count = 0;
        hold_off = 1'b0;
        sh_mode = ModeReset;
        sh_max_gray = MaxGrayReset;
        sh_depth = DepthReset;
        sh_wr = RedWReset;
        sh_wg = GreenWReset;
        sh_wb = BlueWReset;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: byte-packed rgb.
        add_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'hFFFF}, 1'b1, 32'h00FF_FFFF);
        add_row({16'h0000, 16'h0000, 16'h0000, 16'h0, 16'hFFFF}, 1'b1, 32'h0000_0000);
        add_row({16'h1234, 16'hABCD, 16'h5678, 16'h0, 16'hFFFF}, 1'b1, 32'h0012_AB56);
        add_row({16'h0000, 16'h0000, 16'h0000, 16'h0, 16'h0000}, 1'b1, 32'h00FF_FFFF);
        add_row({16'h8000, 16'h4000, 16'h0100, 16'h0, 16'h8000}, 1'b0, 32'd0);
        run_rows();

        write_reg(CFG_MODE, 16'(MODE_WOB));
        add_row({16'h7FFF, 16'h0, 16'h0, 16'h0, 16'hFFFF}, 1'b1, 32'd0);
        add_row({16'h0, 16'h0, 16'h8000, 16'h0, 16'hFFFF}, 1'b1, 32'd1);
        add_row({16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1, 32'd1);
        run_rows();

        write_reg(CFG_MODE, 16'(MODE_BOW));
        add_row({16'h7FFF, 16'h0, 16'h0, 16'h0, 16'hFFFF}, 1'b1, 32'd1);
        add_row({16'h0, 16'h8000, 16'h0, 16'h0, 16'hFFFF}, 1'b1, 32'd0);
        run_rows();

        write_reg(CFG_MODE, 16'(MODE_CMYK));
        add_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0}, 1'b1, 32'hFFFF_FFFE);
        add_row({16'hFF00, 16'hFF00, 16'hFF00, 16'hFEFF, 16'h0}, 1'b1, 32'hFFFF_FFFE);
        add_row({16'h1200, 16'h3400, 16'h5600, 16'h7800, 16'h0}, 1'b1, 32'h1234_5678);
        run_rows();

        write_reg(CFG_MODE, 16'(MODE_GRAY));
        add_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'hFFFF}, 1'b1, 32'd255);
        add_row({16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF}, 1'b1, 32'd0);
        add_row({16'h4000, 16'h9000, 16'h2000, 16'h0, 16'h1234}, 1'b0, 32'd0);
        run_rows();
        write_reg(CFG_RED_W, 16'd0);
        write_reg(CFG_GREEN_W, 16'd0);
        write_reg(CFG_BLUE_W, 16'd0);
        add_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'hFFFF}, 1'b1, 32'd0);
        run_rows();

        write_reg(CFG_MODE, 16'd7);
        add_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, 32'd0);
        run_rows();
        write_reg(CFG_MODE, 16'(MODE_RGB));
        write_reg(CFG_DEPTH, 16'd30);
        add_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'hFFFF}, 1'b1, 32'h3FFF_FFFF);
        run_rows();
        write_reg(CFG_DEPTH, 16'd2);
        add_row({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'hFFFF}, 1'b1, 32'd0);
        run_rows();

        // Random phases: walk each mode with assorted register settings.
        depth_pick = '{5'd3, 5'd24, 5'd31, 5'd0};
        for (int phase = 0; phase < 12; phase++)
        begin
            write_reg(CFG_MODE, (phase % 7 == 6) ? 16'($urandom_range(5, 7))
                                                 : 16'(phase % 5));
            write_reg(CFG_MAX_GRAY, (phase < 4) ? ((phase % 2) ? 16'hFFFF : 16'd1)
                                                : 16'($urandom_range(1, 65535)));
            write_reg(CFG_DEPTH, (phase < 4) ? 16'(depth_pick[phase])
                                             : 16'($urandom_range(3, 30)));
            write_reg(CFG_RED_W, (phase == 2) ? 16'd255 : 16'($urandom_range(0, 255)));
            write_reg(CFG_GREEN_W, (phase == 2) ? 16'd255 : 16'($urandom_range(0, 255)));
            write_reg(CFG_BLUE_W, (phase == 2) ? 16'd255 : 16'($urandom_range(0, 255)));
            for (int i = 0; i < RandItems / 12; i++)
            begin
                // Stall the output for a long stretch once so the pipe backs up.
                if (phase == 5 && i == 10)
                    hold_off = 1'b1;
                send_pixel(rand_pixel(), 1'b0, 32'd0);
            end
            wait_idle();
        end

        repeat (PipeDepth * 3) @(posedge clk);
        $display("covered all five packing modes, unused mode codes, zero weights,");
        $display("depth extremes and alpha blending; %0d indexes checked", results_seen);
        if (mismatches == 0 && pending_index.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== device_color_index_packer.f =====
rtl/clp_pkg.sv
rtl/clp_div.sv
rtl/device_color_index_packer.sv
tb/tb_device_color_index_packer.sv
